### hw/rtl/tre_pkg.sv
// Shared constants, types and helpers of the track row edge tracker.
package tre_pkg;

  localparam int ROW_COUNT    = 60;
  localparam int ROW_WIDTH    = 80;
  localparam int HALF_WIDTH   = 40;
  localparam int IDX_W        = 6;
  localparam int ROW_W        = $clog2(ROW_COUNT);
  localparam int COL_W        = $clog2(ROW_WIDTH);
  localparam int EDGE_W       = 9;
  localparam int WIDE_W       = 11;
  localparam int OFF_W        = 10;
  localparam int CENTER_W     = 7;
  localparam int CLS_W        = 3;
  localparam int SEARCH_MIN   = 3;
  localparam int SEARCH_MAX   = ROW_WIDTH - 4;
  localparam int WHITE_PROBE  = 46;
  localparam int START_RESET  = 40;
  localparam int CENTER_RESET = 40;
  localparam int EDGE_MIN     = -256;
  localparam int EDGE_MAX     = 255;

  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [ROW_W-1:0]            row_t;
  typedef logic [COL_W-1:0]            col_t;
  typedef logic [ROW_WIDTH-1:0]        pix_t;
  typedef logic [HALF_WIDTH-1:0]       half_t;
  typedef logic signed [EDGE_W-1:0]    edge_t;
  typedef logic signed [WIDE_W-1:0]    wide_t;
  typedef logic signed [OFF_W-1:0]     off_t;
  typedef logic [CENTER_W-1:0]         center_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_WHITE = 3'd0,
    CLS_BOTH  = 3'd1,
    CLS_LEFT  = 3'd2,
    CLS_RIGHT = 3'd3,
    CLS_BLACK = 3'd4
  } cls_t;

  // Per-row history word.
  typedef struct packed {
    edge_t start;
    edge_t left;
    edge_t right;
  } entry_t;

  // Outcome of the edge search on one row.
  typedef struct packed {
    logic  found_l;
    logic  found_r;
    edge_t left;
    edge_t right;
    logic  blk;
    logic  wht;
  } srch_t;

  // Final answer for one row plus the history write.
  typedef struct packed {
    edge_t left;
    edge_t right;
    off_t  offset;
    cls_t  cls;
    logic  white;
    logic  store;
    edge_t mid;
  } res_t;

  localparam entry_t ENTRY_RESET = '{
    start: EDGE_W'(START_RESET),
    left:  '0,
    right: EDGE_W'(ROW_WIDTH)
  };

  function automatic edge_t col_to_edge(col_t c);
    return edge_t'(c);
  endfunction

  function automatic edge_t sat_edge(wide_t v);
    edge_t r;
    if (v < wide_t'(EDGE_MIN)) begin
      r = edge_t'(EDGE_MIN);
    end else if (v > wide_t'(EDGE_MAX)) begin
      r = edge_t'(EDGE_MAX);
    end else begin
      r = edge_t'(v);
    end
    return r;
  endfunction

endpackage

### hw/rtl/tre_row_store.sv
// Per-row history memory with valid bits and same-row write forwarding.
module tre_row_store (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  tre_pkg::row_t   rd_row,
  input  logic            wr_en,
  input  tre_pkg::row_t   wr_row,
  input  tre_pkg::entry_t wr_data,
  output tre_pkg::entry_t rd_data
);
  import tre_pkg::*;

  entry_t               mem [ROW_COUNT];
  logic [ROW_COUNT-1:0] vld;
  entry_t               rd_q;
  entry_t               wr_q;
  logic                 rd_vld;
  logic                 fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_row];
      wr_q <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
      fwd    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_row];
        fwd    <= wr_en && (wr_row == rd_row);
      end
    end
  end

  // Unwritten rows read as their reset history.
  assign rd_data = fwd ? wr_q : (rd_vld ? rd_q : ENTRY_RESET);

endmodule

### hw/rtl/tre_edge_search.sv
// Edge search: clamp the start column and priority-encode the boundaries.
module tre_edge_search (
  input  tre_pkg::pix_t  pix,
  input  tre_pkg::edge_t start,
  output tre_pkg::srch_t srch
);
  import tre_pkg::*;

  localparam int PAD = 3;

  logic [ROW_WIDTH+2*PAD-1:0] pe;
  edge_t                      s_c;
  col_t                       col;
  logic                       start_blk;
  logic [ROW_WIDTH-1:0]       up_pat;
  logic [ROW_WIDTH-1:0]       dn_pat;
  logic                       up_hit;
  logic                       dn_hit;
  col_t                       up_idx;
  col_t                       dn_idx;

  // Pad with white on both sides; column c sits at pe[c+PAD].
  assign pe = {{PAD{1'b0}}, pix, {PAD{1'b0}}};

  always_comb begin
    if (start < edge_t'(SEARCH_MIN)) begin
      s_c = edge_t'(SEARCH_MIN);
    end else if (start > edge_t'(SEARCH_MAX)) begin
      s_c = edge_t'(SEARCH_MAX);
    end else begin
      s_c = start;
    end
    col       = COL_W'(s_c);
    start_blk = pix[col];
  end

  // Boundary patterns, limited to the search span and masked by the start.
  always_comb begin
    for (int i = 0; i < ROW_WIDTH; i++) begin
      if (start_blk) begin
        up_pat[i] = pe[i+PAD] & ~pe[i+PAD+1] & ~pe[i+PAD+2] & ~pe[i+PAD+3];
        dn_pat[i] = pe[i+PAD] & ~pe[i+PAD-1] & ~pe[i+PAD-2] & ~pe[i+PAD-3];
      end else begin
        up_pat[i] = ~pe[i+PAD] & pe[i+PAD+1] & pe[i+PAD+2] & pe[i+PAD+3];
        dn_pat[i] = ~pe[i+PAD] & pe[i+PAD-1] & pe[i+PAD-2] & pe[i+PAD-3];
      end
      if (i < SEARCH_MIN || i > SEARCH_MAX) begin
        up_pat[i] = 1'b0;
        dn_pat[i] = 1'b0;
      end
      if (COL_W'(i) < col) begin
        up_pat[i] = 1'b0;
      end
      if (COL_W'(i) > col) begin
        dn_pat[i] = 1'b0;
      end
    end
  end

  // Nearest hit above and below the start.
  always_comb begin
    up_hit = 1'b0;
    up_idx = '0;
    for (int i = ROW_WIDTH - 1; i >= 0; i--) begin
      if (up_pat[i]) begin
        up_hit = 1'b1;
        up_idx = COL_W'(i);
      end
    end
    dn_hit = 1'b0;
    dn_idx = '0;
    for (int i = 0; i < ROW_WIDTH; i++) begin
      if (dn_pat[i]) begin
        dn_hit = 1'b1;
        dn_idx = COL_W'(i);
      end
    end
  end

  always_comb begin
    srch.left  = '0;
    srch.right = edge_t'(ROW_WIDTH);
    if (start_blk) begin
      srch.found_l = up_hit;
      srch.found_r = dn_hit;
      if (up_hit) begin
        srch.left = col_to_edge(up_idx) + edge_t'(1);
      end
      if (dn_hit) begin
        srch.right = col_to_edge(dn_idx) - edge_t'(1);
      end
    end else begin
      srch.found_l = dn_hit;
      srch.found_r = up_hit;
      if (dn_hit) begin
        srch.left = col_to_edge(dn_idx) - edge_t'(1);
      end
      if (up_hit) begin
        srch.right = col_to_edge(up_idx) + edge_t'(1);
      end
    end
    srch.blk = pe[SEARCH_MIN+PAD] & pe[SEARCH_MAX+PAD];
    srch.wht = ~pe[SEARCH_MIN+PAD] & ~pe[WHITE_PROBE+PAD] & ~pe[SEARCH_MAX+PAD];
  end

endmodule

### hw/rtl/tre_edge_resolve.sv
// Edge resolve: classify, extrapolate a missing edge, saturate, form the offset.
module tre_edge_resolve (
  input  tre_pkg::srch_t   srch,
  input  tre_pkg::entry_t  prev,
  input  tre_pkg::center_t center,
  output tre_pkg::res_t    res
);
  import tre_pkg::*;

  wide_t l_w;
  wide_t r_w;
  edge_t l_s;
  edge_t r_s;
  wide_t sum;
  wide_t half;
  wide_t off_w;
  logic  none;

  always_comb begin
    none = ~srch.found_l & ~srch.found_r;
    l_w  = wide_t'(srch.left);
    r_w  = wide_t'(srch.right);
    if (srch.found_l && !srch.found_r) begin
      r_w = wide_t'(prev.right) + (wide_t'(srch.left) - wide_t'(prev.left));
    end else if (!srch.found_l) begin
      l_w = wide_t'(prev.left) + (wide_t'(srch.right) - wide_t'(prev.right));
    end
    l_s   = sat_edge(l_w);
    r_s   = sat_edge(r_w);
    sum   = wide_t'(l_s) + wide_t'(r_s);
    // Round toward zero: bias negative sums before the shift.
    half  = (sum + wide_t'(sum[WIDE_W-1])) >>> 1;
    off_w = wide_t'({1'b0, center}) - half;

    res.left   = l_s;
    res.right  = r_s;
    res.offset = OFF_W'(off_w);
    res.white  = 1'b0;
    res.store  = 1'b1;
    res.mid    = EDGE_W'(half);
    if (srch.found_l && srch.found_r) begin
      res.cls = CLS_BOTH;
    end else if (srch.found_l) begin
      res.cls = CLS_LEFT;
    end else begin
      res.cls = CLS_RIGHT;
    end

    if (none && (srch.blk || srch.wht)) begin
      res.left   = '0;
      res.right  = edge_t'(ROW_WIDTH);
      res.offset = '0;
      res.store  = 1'b0;
      if (srch.blk) begin
        res.cls = CLS_BLACK;
      end else begin
        res.cls   = CLS_WHITE;
        res.white = 1'b1;
      end
    end
  end

endmodule

### hw/rtl/track_row_edge_tracker_core.sv
// Top level of the track row edge tracker: sequencer, history memory and result register.
//
// Usage:
//   Input channel (in_valid / in_stall): one item is one binarized camera row,
//   pixels_low holds columns 0..39 and pixels_high columns 40..79 (1 = black),
//   with its row_index; indexes at or above the row count wrap back by it.
//   Output channel (out_valid / out_stall): one result item per input item
//   with both edges, the row class, the all-white flag and the steering offset.
//   Configuration: cfg_wr_en / cfg_wr_data write center_column; write it only
//   while no item is in flight.
// Item sequence:
//   An accepted item is read from the history memory as it is taken, its
//   search outcome is registered in S_SRCH, and in S_FIN it is resolved,
//   written back and loaded into the result register. The next item is
//   taken in the same cycle the previous one finishes: the read-search-resolve
//   sequence around the history memory holds one item at a time.
//   Same-row back-to-back items see the just-written history by forwarding.
// Reset: clears the sequencer and the result valid flag, loads center_column
//   with 40 and marks every row of the history as unwritten, which reads as
//   start 40, left 0, right 80. No clearing pass is needed.
// Stall: a held result blocks the resolve step; the sequencer and the input
//   side hold until the result register is free again.
module track_row_edge_tracker_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  tre_pkg::center_t  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  tre_pkg::idx_t     row_index,
  input  tre_pkg::half_t    pixels_low,
  input  tre_pkg::half_t    pixels_high,
  output logic              out_valid,
  input  logic              out_stall,
  output tre_pkg::edge_t    left_edge,
  output tre_pkg::edge_t    right_edge,
  output tre_pkg::off_t     steer_offset,
  output logic [2:0]        row_class,
  output logic              all_white
);
  import tre_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_FIN
  } state_t;

  state_t  state;
  center_t center;
  pix_t    pix;
  row_t    row;
  row_t    row_in;
  srch_t   srch;
  srch_t   srch_q;
  entry_t  rd_entry;
  entry_t  prev_q;
  entry_t  wr_entry;
  res_t    res;
  logic    in_accept;
  logic    fin_go;
  logic    wr_en;

  // Wrap the incoming row number into the history range.
  always_comb begin
    if (row_index >= IDX_W'(ROW_COUNT)) begin
      row_in = ROW_W'(row_index - IDX_W'(ROW_COUNT));
    end else begin
      row_in = ROW_W'(row_index);
    end
  end

  // Resolve may finish once the result register is free or being drained.
  assign fin_go = ~out_valid | ~out_stall;

  always_comb begin
    unique case (state)
      S_IDLE:  in_stall = 1'b0;
      S_SRCH:  in_stall = 1'b1;
      S_FIN:   in_stall = ~fin_go;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_accept = in_valid & ~in_stall;
  assign wr_en     = (state == S_FIN) & fin_go & res.store;
  assign wr_entry  = '{start: res.mid, left: res.left, right: res.right};

  always_ff @(posedge clk) begin
    if (rst) begin
      center <= CENTER_W'(CENTER_RESET);
    end else if (cfg_wr_en) begin
      center <= cfg_wr_data;
    end
  end

  tre_row_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_row  (row_in),
    .wr_en   (wr_en),
    .wr_row  (row),
    .wr_data (wr_entry),
    .rd_data (rd_entry)
  );

  tre_edge_search u_search (
    .pix   (pix),
    .start (rd_entry.start),
    .srch  (srch)
  );

  tre_edge_resolve u_resolve (
    .srch   (srch_q),
    .prev   (prev_q),
    .center (center),
    .res    (res)
  );

  // Item payload: capture on accept, hold the search outcome for resolve.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pix <= {pixels_high, pixels_low};
      row <= row_in;
    end
    if (state == S_SRCH) begin
      srch_q <= srch;
      prev_q <= rd_entry;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the drained result unless resolve refills the register now.
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid    <= 1'b1;
            left_edge    <= res.left;
            right_edge   <= res.right;
            steer_offset <= res.offset;
            row_class    <= res.cls;
            all_white    <= res.white;
            state        <= in_accept ? S_SRCH : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/track_row_edge_tracker_core_test.sv
// Self-checking testbench of the track row edge tracker core.
module track_row_edge_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tre_pkg::*;

  // Cycles without any accepted item before the run is declared hung.
  localparam int QUIET_LIMIT      = 4000;
  localparam int SHOWN_MISMATCHES = 10;

  // One expected result item.
  typedef struct {
    edge_t left;
    edge_t right;
    off_t  offset;
    cls_t  cls;
    logic  white;
  } row_answer_t;

  // Tracks per-row history the way the core should, and queues the answer
  // for every row item the core accepts.
  class row_edge_board;
    int start_col[ROW_COUNT];
    int seen_left[ROW_COUNT];
    int seen_right[ROW_COUNT];
    int center;
    int failures;
    row_answer_t due[$];

    function new();
      int r;
      for (r = 0; r < ROW_COUNT; r++) begin
        start_col[r]  = START_RESET;
        seen_left[r]  = 0;
        seen_right[r] = ROW_WIDTH;
      end
      center   = CENTER_RESET;
      failures = 0;
    endfunction

    // Columns outside the row read as white.
    function bit dark(pix_t p, int c);
      if (c < 0 || c >= ROW_WIDTH) return 1'b0;
      return p[c];
    endfunction

    function int clip(int v);
      if (v < EDGE_MIN) return EDGE_MIN;
      if (v > EDGE_MAX) return EDGE_MAX;
      return v;
    endfunction

    function void take_row(idx_t idx, half_t lo, half_t hi);
      pix_t        p;
      int          r, s, i, lf, rt, mid;
      bit          got_l, got_r;
      row_answer_t a;
      p = {hi, lo};
      r = int'(idx) % ROW_COUNT;
      s = start_col[r];
      if (s < SEARCH_MIN) s = SEARCH_MIN;
      if (s > SEARCH_MAX) s = SEARCH_MAX;
      start_col[r] = s;
      lf = 0;
      rt = ROW_WIDTH;
      got_l = 1'b0;
      got_r = 1'b0;
      if (dark(p, s)) begin
        // Standing on black: look for black followed by three white pixels.
        for (i = s; i <= SEARCH_MAX && !got_l; i++)
          if (dark(p, i) && !dark(p, i+1) && !dark(p, i+2) && !dark(p, i+3)) begin
            lf = i + 1;
            got_l = 1'b1;
          end
        for (i = s; i >= SEARCH_MIN && !got_r; i--)
          if (dark(p, i) && !dark(p, i-1) && !dark(p, i-2) && !dark(p, i-3)) begin
            rt = i - 1;
            got_r = 1'b1;
          end
      end else begin
        for (i = s; i >= SEARCH_MIN && !got_l; i--)
          if (!dark(p, i) && dark(p, i-1) && dark(p, i-2) && dark(p, i-3)) begin
            lf = i - 1;
            got_l = 1'b1;
          end
        for (i = s; i <= SEARCH_MAX && !got_r; i++)
          if (!dark(p, i) && dark(p, i+1) && dark(p, i+2) && dark(p, i+3)) begin
            rt = i + 1;
            got_r = 1'b1;
          end
      end
      a.white = 1'b0;
      if (!got_l && !got_r && dark(p, SEARCH_MIN) && dark(p, SEARCH_MAX)) begin
        a.left   = '0;
        a.right  = edge_t'(ROW_WIDTH);
        a.offset = '0;
        a.cls    = CLS_BLACK;
      end else if (!got_l && !got_r && !dark(p, SEARCH_MIN) && !dark(p, WHITE_PROBE) &&
                   !dark(p, SEARCH_MAX)) begin
        a.left   = '0;
        a.right  = edge_t'(ROW_WIDTH);
        a.offset = '0;
        a.cls    = CLS_WHITE;
        a.white  = 1'b1;
      end else begin
        // Any other row without edges ends up in the right-only rule.
        if (got_l && got_r) begin
          a.cls = CLS_BOTH;
        end else if (got_l) begin
          rt = seen_right[r] + (lf - seen_left[r]);
          a.cls = CLS_LEFT;
        end else begin
          lf = seen_left[r] + (rt - seen_right[r]);
          a.cls = CLS_RIGHT;
        end
        lf  = clip(lf);
        rt  = clip(rt);
        mid = (lf + rt) / 2;
        start_col[r]  = mid;
        seen_left[r]  = lf;
        seen_right[r] = rt;
        a.left   = edge_t'(lf);
        a.right  = edge_t'(rt);
        a.offset = off_t'(center - mid);
      end
      due.push_back(a);
    endfunction

    function void match_result(edge_t l, edge_t r, off_t off, logic [2:0] cls, logic white);
      row_answer_t a;
      if (due.size() == 0) begin
        failures++;
        if (failures <= SHOWN_MISMATCHES)
          $display("unexpected result item: left %0d right %0d offset %0d class %0d",
                   l, r, off, cls);
        return;
      end
      a = due.pop_front();
      if (l !== a.left || r !== a.right || off !== a.offset || cls !== a.cls ||
          white !== a.white) begin
        failures++;
        if (failures <= SHOWN_MISMATCHES)
          $display("result mismatch: expected left %0d right %0d offset %0d class %0d white %0d",
                   a.left, a.right, a.offset, a.cls, a.white,
                   " / got left %0d right %0d offset %0d class %0d white %0d",
                   l, r, off, cls, white);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  center_t    cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  idx_t       row_index;
  half_t      pixels_low;
  half_t      pixels_high;
  logic       out_valid;
  logic       out_stall;
  edge_t      left_edge;
  edge_t      right_edge;
  off_t       steer_offset;
  logic [2:0] row_class;
  logic       all_white;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet         = 0;

  row_edge_board board;

  track_row_edge_tracker_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .row_index    (row_index),
    .pixels_low   (pixels_low),
    .pixels_high  (pixels_high),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .left_edge    (left_edge),
    .right_edge   (right_edge),
    .steer_offset (steer_offset),
    .row_class    (row_class),
    .all_white    (all_white)
  );

  always #1ns clk = ~clk;

  // Receiver side: stall at random with the current percentage.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every accepted result item and watch for a hung core. Values are
  // read at the edge, before any nonblocking update lands.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        board.match_result(left_edge, right_edge, steer_offset, row_class, all_white);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Black row with a white band over columns lo_col..hi_col.
  function automatic pix_t band_row(int lo_col, int hi_col);
    pix_t p;
    int   c;
    p = '1;
    for (c = lo_col; c <= hi_col; c++) p[c] = 1'b0;
    return p;
  endfunction

  // Present one row item, idling at random first; valid stays high after
  // acceptance so back-to-back items never toggle it within one step.
  task automatic send_row(idx_t idx, pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    row_index   <= idx;
    pixels_low  <= p[HALF_WIDTH-1:0];
    pixels_high <= p[ROW_WIDTH-1:HALF_WIDTH];
    do @(posedge clk); while (in_stall);
    board.take_row(idx, p[HALF_WIDTH-1:0], p[ROW_WIDTH-1:HALF_WIDTH]);
  endtask

  // Drop valid and hold until every expected result item has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.due.size() != 0);
  endtask

  // Write center_column only once the core is empty.
  task automatic set_center(int v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= center_t'(v);
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    board.center  = v;
  endtask

  task automatic run_directed();
    pix_t p;
    send_idle_pct = 0;
    stall_pct     = 0;
    send_row(0, '0);                        // all white
    send_row(0, '1);                        // all black
    send_row(1, band_row(20, 60));          // both edges found
    send_row(1, band_row(10, 79));          // left edge only, right extrapolated
    send_row(1, band_row(0, 50));           // right edge only, left extrapolated
    p = '0;
    p[WHITE_PROBE] = 1'b1;
    send_row(2, p);                         // no edge, neither all white nor all black
    send_row(60, band_row(25, 55));         // index past the last row wraps
    send_row(63, band_row(5, 70));
    send_row(59, band_row(30, 75));
    send_row(4, ~band_row(30, 50));         // black band: search starts on black
    send_row(4, ~band_row(35, 60));
    send_row(8, band_row(3, 76));           // edges at the outer search limits
    send_row(5, {(ROW_WIDTH/2){2'b01}});
    send_row(5, {(ROW_WIDTH/2){2'b10}});
    send_row(6, {{HALF_WIDTH{1'b1}}, {HALF_WIDTH{1'b0}}});
    send_row(6, {{HALF_WIDTH{1'b0}}, {HALF_WIDTH{1'b1}}});
    send_row(9, band_row(20, 60));          // drift the history with one-sided rows
    send_row(9, band_row(50, 79));
    send_row(9, band_row(0, 15));
    send_row(9, band_row(60, 79));
  endtask

  // Mostly track-like rows with random edges on a few busy rows, then noisy
  // tracks, solid rows and plain random rows.
  task automatic run_random(int count, int send_pct, int recv_pct);
    int   n, kind, a, b;
    idx_t idx;
    pix_t p, noise;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      if ($urandom_range(99) < 70) idx = idx_t'($urandom_range(3));
      else idx = idx_t'($urandom_range(63));
      kind  = $urandom_range(99);
      a     = $urandom_range(50);
      b     = $urandom_range(79, a);
      noise = pix_t'({$urandom, $urandom, $urandom}) &
              pix_t'({$urandom, $urandom, $urandom}) &
              pix_t'({$urandom, $urandom, $urandom});
      if (kind < 50) p = band_row(a, b);
      else if (kind < 60) p = ~band_row(a, b);
      else if (kind < 65) p = '1;
      else if (kind < 70) p = '0;
      else if (kind < 85) p = band_row(a, b) ^ noise;
      else p = pix_t'({$urandom, $urandom, $urandom});
      send_row(idx, p);
    end
  endtask

  initial begin
    board = new();
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    row_index   <= '0;
    pixels_low  <= '0;
    pixels_high <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_center(CENTER_RESET);
    run_directed();

    // Sender idles a quarter of the time, receiver stalls most of it.
    set_center(0);
    run_random(230, 25, 71);

    // Swap the roles.
    set_center(79);
    run_random(230, 71, 25);

    // Full rate on both sides.
    set_center($urandom_range(1, 78));
    run_random(230, 0, 0);

    drain();
    repeat (8) @(posedge clk);
    if (board.failures == 0 && board.due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### sim.f
hw/rtl/tre_pkg.sv
hw/rtl/tre_row_store.sv
hw/rtl/tre_edge_search.sv
hw/rtl/tre_edge_resolve.sv
hw/rtl/track_row_edge_tracker_core.sv
sim/track_row_edge_tracker_core_test.sv
